/* rtl/scb_pkg.sv */
package scb_pkg;

   localparam int CMD_W   = 8;
   localparam int DEST_W  = 4;
   localparam int OPND_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int OUTC_W  = 2;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;
   localparam int LUT_N   = 256;

   localparam logic [CMD_W-1:0] CMD_SET_IMM = 8'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_IMM = 8'd1;
   localparam logic [CMD_W-1:0] CMD_SUB_IMM = 8'd2;
   localparam logic [CMD_W-1:0] CMD_SET_IDX = 8'd3;
   localparam logic [CMD_W-1:0] CMD_ADD_IDX = 8'd4;
   localparam logic [CMD_W-1:0] CMD_SUB_IDX = 8'd5;
   localparam logic [CMD_W-1:0] CMD_EQ_IMM  = 8'd6;
   localparam logic [CMD_W-1:0] CMD_NE_IMM  = 8'd7;
   localparam logic [CMD_W-1:0] CMD_GT_IMM  = 8'd8;
   localparam logic [CMD_W-1:0] CMD_GE_IMM  = 8'd9;
   localparam logic [CMD_W-1:0] CMD_LE_IMM  = 8'd10;
   localparam logic [CMD_W-1:0] CMD_LT_IMM  = 8'd11;
   localparam logic [CMD_W-1:0] CMD_EQ_IDX  = 8'd12;
   localparam logic [CMD_W-1:0] CMD_NE_IDX  = 8'd13;
   localparam logic [CMD_W-1:0] CMD_GT_IDX  = 8'd14;
   localparam logic [CMD_W-1:0] CMD_GE_IDX  = 8'd15;
   localparam logic [CMD_W-1:0] CMD_LE_IDX  = 8'd16;
   localparam logic [CMD_W-1:0] CMD_LT_IDX  = 8'd17;

   localparam logic [OUTC_W-1:0] OUT_NONE = 2'd0;
   localparam logic [OUTC_W-1:0] OUT_TAKE = 2'd1;
   localparam logic [OUTC_W-1:0] OUT_SKIP = 2'd2;

   typedef struct packed {
      logic                 wr_en;
      logic [OUTC_W-1:0]    outcome;
      logic [BYTE_W-1:0]    value;
   } exec_result_type;

endpackage

/* rtl/scratch_byte_alu_compare_unit.sv */
// scratch byte alu / compare unit
// req channel carries one command per request: cmd, dest_index, operand.
// commands 0-5 write set/add/sub results into a byte of the scratch store,
// commands 6-17 compare a store byte against an immediate or a second byte.
// rsp channel returns one item per request: outcome (none/take/skip) and the
// destination byte as it stands after the command.
// a request accepted into the input register moves on to the result register
// when that is free; its response is then shown from the result register.
// throughput: one request per cycle while rsp_tready is high; the
// read-modify-write of the store is closed with a bypass from the write port
// to the read registers, so back-to-back commands on the same byte see fresh data.
// when rsp_tready is low the response holds and one more request is
// buffered in the input register; req_tready drops after that.
// reset (synchronous) empties both registers and clears the store valid
// bits, so every byte reads zero; no clearing pass is needed.
module scratch_byte_alu_compare_unit #(
   parameter int SCRATCH_BYTES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [scb_pkg::REQ_W-1:0]  req_tdata,  // cmd[7:0], dest_index[11:8], operand[19:12]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [scb_pkg::RSP_W-1:0]  rsp_tdata   // outcome[1:0], stored_value[9:2]
);
   import scb_pkg::*;

   localparam int IDX_W = (SCRATCH_BYTES > 1) ? $clog2(SCRATCH_BYTES) : 1;

   logic [IDX_W-1:0]  wrap_lut [LUT_N];

   logic [CMD_W-1:0]  req_cmd;
   logic [DEST_W-1:0] req_dest;
   logic [OPND_W-1:0] req_opnd;
   logic [IDX_W-1:0]  req_dest_idx;
   logic [IDX_W-1:0]  req_opnd_idx;
   logic              req_accept;
   logic              advance;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [IDX_W-1:0]  s1_dest_ff;
   logic [OPND_W-1:0] s1_opnd_ff;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [OUTC_W-1:0] out_outcome_ff;
   logic [BYTE_W-1:0] out_value_ff;

   logic [BYTE_W-1:0] dest_data;
   logic [BYTE_W-1:0] opnd_data;
   exec_result_type   exec_res;

   // index wrap modulo the store size, worked out at elaboration
   for (genvar g = 0; g < LUT_N; g++) begin : g_wrap
      assign wrap_lut[g] = IDX_W'(g % SCRATCH_BYTES);
   end

   assign req_cmd      = req_tdata[7:0];
   assign req_dest     = req_tdata[11:8];
   assign req_opnd     = req_tdata[19:12];
   assign req_dest_idx = wrap_lut[{4'h0, req_dest}];
   assign req_opnd_idx = wrap_lut[req_opnd];

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_dest_ff <= req_dest_idx;
         s1_opnd_ff <= req_opnd;
      end
      if (advance) begin
         out_outcome_ff <= exec_res.outcome;
         out_value_ff   <= exec_res.value;
      end
   end

   scb_store #(
      .SCRATCH_BYTES (SCRATCH_BYTES),
      .IDX_W         (IDX_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (req_accept),
      .rd_dest_addr (req_dest_idx),
      .rd_opnd_addr (req_opnd_idx),
      .wr_en        (advance && exec_res.wr_en),
      .wr_addr      (s1_dest_ff),
      .wr_data      (exec_res.value),
      .dest_data    (dest_data),
      .opnd_data    (opnd_data)
   );

   scb_exec u_exec (
      .cmd       (s1_cmd_ff),
      .cur       (dest_data),
      .opnd_data (opnd_data),
      .operand   (s1_opnd_ff),
      .result    (exec_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'h00, out_value_ff, out_outcome_ff};

endmodule

/* rtl/scb_store.sv */
module scb_store #(
   parameter int SCRATCH_BYTES = 16,
   parameter int IDX_W         = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_dest_addr,
   input  logic [IDX_W-1:0]  rd_opnd_addr,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        dest_data,
   output logic [7:0]        opnd_data
);
   import scb_pkg::*;

   logic [BYTE_W-1:0]        mem_ff [SCRATCH_BYTES];
   logic [SCRATCH_BYTES-1:0] valid_ff;
   logic [BYTE_W-1:0]        dest_raw_ff;
   logic [BYTE_W-1:0]        opnd_raw_ff;
   logic                     dest_ok_ff;
   logic                     opnd_ok_ff;
   logic                     dest_byp_ff;
   logic                     opnd_byp_ff;
   logic [BYTE_W-1:0]        byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         dest_raw_ff <= mem_ff[rd_dest_addr];
         opnd_raw_ff <= mem_ff[rd_opnd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // a write landing on the same edge as the read is forwarded
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ok_ff  <= 1'b0;
         opnd_ok_ff  <= 1'b0;
         dest_byp_ff <= 1'b0;
         opnd_byp_ff <= 1'b0;
      end else if (rd_en) begin
         dest_ok_ff  <= valid_ff[rd_dest_addr];
         opnd_ok_ff  <= valid_ff[rd_opnd_addr];
         dest_byp_ff <= wr_en && (wr_addr == rd_dest_addr);
         opnd_byp_ff <= wr_en && (wr_addr == rd_opnd_addr);
      end
   end

   assign dest_data = dest_byp_ff ? byp_data_ff : (dest_ok_ff ? dest_raw_ff : '0);
   assign opnd_data = opnd_byp_ff ? byp_data_ff : (opnd_ok_ff ? opnd_raw_ff : '0);

endmodule

/* rtl/scb_exec.sv */
module scb_exec (
   input  logic [7:0]                cmd,
   input  logic [7:0]                cur,
   input  logic [7:0]                opnd_data,
   input  logic [7:0]                operand,
   output scb_pkg::exec_result_type  result
);
   import scb_pkg::*;

   logic              indexed;
   logic [BYTE_W-1:0] other;
   logic              is_cmp;
   logic              cond;

   assign indexed = ((cmd >= CMD_SET_IDX) && (cmd <= CMD_SUB_IDX))
                 || ((cmd >= CMD_EQ_IDX) && (cmd <= CMD_LT_IDX));
   assign other   = indexed ? opnd_data : operand;

   always_comb begin
      result.wr_en = 1'b0;
      result.value = cur;
      is_cmp       = 1'b0;
      cond         = 1'b0;
      unique case (cmd)
         CMD_SET_IMM, CMD_SET_IDX: begin
            result.wr_en = 1'b1;
            result.value = other;
         end
         CMD_ADD_IMM, CMD_ADD_IDX: begin
            result.wr_en = 1'b1;
            result.value = cur + other;
         end
         CMD_SUB_IMM, CMD_SUB_IDX: begin
            result.wr_en = 1'b1;
            result.value = cur - other;
         end
         CMD_EQ_IMM, CMD_EQ_IDX: begin
            is_cmp = 1'b1;
            cond   = (cur == other);
         end
         CMD_NE_IMM, CMD_NE_IDX: begin
            is_cmp = 1'b1;
            cond   = (cur != other);
         end
         CMD_GT_IMM, CMD_GT_IDX: begin
            is_cmp = 1'b1;
            cond   = (cur > other);
         end
         CMD_GE_IMM, CMD_GE_IDX: begin
            is_cmp = 1'b1;
            cond   = (cur >= other);
         end
         CMD_LE_IMM, CMD_LE_IDX: begin
            is_cmp = 1'b1;
            cond   = (cur <= other);
         end
         CMD_LT_IMM, CMD_LT_IDX: begin
            is_cmp = 1'b1;
            cond   = (cur < other);
         end
         default: begin
         end
      endcase
      result.outcome = is_cmp ? (cond ? OUT_TAKE : OUT_SKIP) : OUT_NONE;
   end

endmodule

/* rtl/scb_checker.sv */
module scb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [scb_pkg::RSP_W-1:0]  rsp_tdata
);
   import scb_pkg::*;

   // stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == OUT_NONE) || (rsp_tdata[1:0] == OUT_TAKE)
                  || (rsp_tdata[1:0] == OUT_SKIP))
      else $error("bad outcome code");

   // back-pressure only when the result register is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without output stall");

   // an accepted request reaches the output through the input and result registers when not stalled
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("response missing after request");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind scratch_byte_alu_compare_unit scb_checker u_scb_checker (.*);
